// File: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int ValW = 32;
  localparam int PriW = 32;
  localparam int OccW = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    latch_req;  // capture the incoming request
    logic    init_k;     // start the tail walk at the entry count
    logic    rd_tail;    // read logical position k-1
    logic    rd_head;    // read the head slot
    logic    wr_shift;   // move read entry one position back, k--
    logic    wr_new;     // drop the new entry into position k
    logic    load_out;   // commit state and load the result register
    status_e st;         // status for load_out
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic k_zero;
    logic prio_gt;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/spq_ctrl.sv
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_type_i,
  output logic          req_ready_o,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INS_RD  = 5'b00010,
    S_INS_CMP = 5'b00100,
    S_REM_RD  = 5'b01000,
    S_RESP    = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  spq_pkg::status_e st_q, st_d;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    cmd_o       = '0;
    cmd_o.st    = st_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          st_d = spq_pkg::ST_OK;
          if (req_type_i == spq_pkg::REQ_INSERT) begin
            if (stat_i.full) begin
              st_d    = spq_pkg::ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_o.init_k = 1'b1;
              state_d      = S_INS_RD;
            end
          end else begin
            if (stat_i.empty) begin
              st_d    = spq_pkg::ST_EMPTY;
              state_d = S_RESP;
            end else begin
              state_d = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (stat_i.k_zero) begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_RESP;
        end else begin
          cmd_o.rd_tail = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat_i.prio_gt) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = S_INS_RD;
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_REM_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= spq_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

// File: rtl/core/spq_dp.sv
module spq_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_type_i,
  input  logic [spq_pkg::ValW-1:0]   entry_value_i,
  input  logic [spq_pkg::PriW-1:0]   entry_priority_i,
  input  spq_pkg::cmd_t              cmd_i,
  output spq_pkg::stat_t             stat_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [spq_pkg::ValW-1:0]   out_value_o,
  output logic [spq_pkg::PriW-1:0]   out_priority_o,
  output logic [spq_pkg::OccW-1:0]   occupancy_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = spq_pkg::ValW + spq_pkg::PriW;

  // entry word: {priority, value}
  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_q;

  logic                     req_q;
  logic [spq_pkg::ValW-1:0] val_q;
  logic [spq_pkg::PriW-1:0] pri_q;
  logic [IW-1:0]            k_q, k_d;
  logic [IW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;

  logic                     ovalid_q, ovalid_d;
  spq_pkg::status_e         ost_q;
  logic [spq_pkg::ValW-1:0] oval_q;
  logic [spq_pkg::PriW-1:0] opri_q;
  logic [spq_pkg::OccW-1:0] occ_q;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          rem_ok;

  // ring slot of logical position pos
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [IW-1:0] pos);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IW+1)'(QUEUE_DEPTH)) sum = sum - (IW+1)'(QUEUE_DEPTH);
    return sum[IW-1:0];
  endfunction

  assign rd_en   = cmd_i.rd_tail | cmd_i.rd_head;
  assign rd_addr = cmd_i.rd_head ? head_q : slot_of(head_q, k_q - 1'b1);
  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_new;
  assign wr_addr = slot_of(head_q, k_q);
  assign wr_data = cmd_i.wr_shift ? rd_q : {pri_q, val_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_type_i;
      val_q <= entry_value_i;
      pri_q <= entry_priority_i;
    end
  end

  assign stat_o.full     = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.prio_gt  = $signed(rd_q[EW-1:spq_pkg::ValW]) > $signed(pri_q);
  assign stat_o.out_free = !ovalid_q || out_ready_i;

  assign rem_ok = (req_q == spq_pkg::REQ_REMOVE) && (cmd_i.st == spq_pkg::ST_OK);

  always_comb begin
    k_d      = k_q;
    head_d   = head_q;
    count_d  = count_q;
    ovalid_d = ovalid_q;
    if (cmd_i.init_k)   k_d = IW'(count_q);
    if (cmd_i.wr_shift) k_d = k_q - 1'b1;
    if (out_ready_i)    ovalid_d = 1'b0;
    if (cmd_i.load_out) begin
      ovalid_d = 1'b1;
      if (cmd_i.st == spq_pkg::ST_OK) begin
        if (req_q == spq_pkg::REQ_INSERT) begin
          count_d = count_q + 1'b1;
        end else begin
          count_d = count_q - 1'b1;
          if (count_q == CW'(1))                    head_d = '0;
          else if (head_q == IW'(QUEUE_DEPTH - 1))  head_d = '0;
          else                                      head_d = head_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      head_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      k_q      <= k_d;
      head_q   <= head_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ost_q  <= cmd_i.st;
      oval_q <= rem_ok ? rd_q[spq_pkg::ValW-1:0] : '0;
      opri_q <= rem_ok ? rd_q[EW-1:spq_pkg::ValW] : '0;
      occ_q  <= spq_pkg::OccW'(count_d);
    end
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ost_q;
  assign out_value_o    = oval_q;
  assign out_priority_o = opri_q;
  assign occupancy_o    = occ_q;

endmodule

// File: rtl/core/sorted_priority_queue_top.sv
// Sorted priority queue: up to QUEUE_DEPTH (value, priority) entries, kept in
// ascending priority order, ties leave in arrival order.
// Input channel (s_axis): tuser = req_type (0 insert, 1 remove), tdata carries
// the entry for an insert. Output channel (m_axis): one transfer per request,
// tuser = status (0 ok, 1 full, 2 empty), tdata = removed entry (zero
// otherwise) and the occupancy after the request.
// Requests are handled one at a time: the next one is taken only after the
// result of the last is loaded into the output register. Steps per request:
//   refused insert or remove on empty queue: straight to the result
//   remove: one registered read of the head slot, then the result
//   insert: tail walk from the last entry, then the new entry is written
//   into the freed position, then the result.
// Each step of the tail walk reads one entry from the entry memory, compares
// priorities, then writes it one slot further back if its priority is
// greater than the new one's; else, or at the head, the walk ends.
// Reset empties the queue (count and head cleared); the entry memory is not
// cleared, slots are only read once written.
// The result sits in an output register; a new request is taken while it
// waits, and the block holds its next result until the receiver takes it.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] entry_value, [63:32] entry_priority
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] out_value, [63:32] out_priority,
                                        // [67:64] occupancy, [71:68] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  logic [spq_pkg::ValW-1:0] out_value;
  logic [spq_pkg::PriW-1:0] out_priority;
  logic [spq_pkg::OccW-1:0] occupancy;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_type_i  (s_axis_tuser_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (s_axis_tuser_i),
    .entry_value_i    (s_axis_tdata_i[31:0]),
    .entry_priority_i (s_axis_tdata_i[63:32]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .status_o         (m_axis_tuser_o),
    .out_value_o      (out_value),
    .out_priority_o   (out_priority),
    .occupancy_o      (occupancy)
  );

  assign m_axis_tdata_o = {4'b0000, occupancy, out_priority, out_value};

`ifndef SYNTHESIS
  // one request in flight: an input transfer closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a request is in flight");

  // a refused insert only happens with the queue full
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == spq_pkg::ST_FULL)
    |-> m_axis_tdata_o[67:64] == 4'(QUEUE_DEPTH))
    else $error("full status with wrong occupancy");

  // empty status carries no entry and zero occupancy
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == spq_pkg::ST_EMPTY)
    |-> m_axis_tdata_o == '0)
    else $error("empty status with nonzero payload");
`endif

endmodule

// File: verif/sorted_priority_queue_top_test.sv
module sorted_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QueueDepth = 8;
  localparam int OpeningN = 24;
  localparam int RandomN = 650;
  localparam int SettleCycles = 60;
  localparam int LongHold = 100;

  // One result as seen on m_axis, fields split out.
  typedef struct packed {
    spq_pkg::status_e status;
    logic [31:0]      value;
    logic [31:0]      prio;
    logic [3:0]       occ;
  } result_t;

  typedef struct packed {
    logic [31:0]         value;
    logic signed [31:0]  prio;
  } entry_t;

  // Opening table row; 'typed' marks rows whose result is written in below.
  typedef struct packed {
    logic         req;
    logic [31:0]  value;
    logic [31:0]  prio;
    logic         typed;
    result_t      want;
  } step_t;

  localparam step_t OpeningSteps [OpeningN] = '{
    // remove from a fresh queue
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b1,
      '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 4'd0}},
    // fill with extremes and ties
    '{spq_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h0000_0005, 32'h0000_0000, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h0000_0006, 32'h7fff_ffff, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h0000_0007, 32'h8000_0000, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'h0000_0008, 32'h0000_0064, 1'b0, '0},
    // insert into a full queue is refused
    '{spq_pkg::REQ_INSERT, 32'h1234_5678, 32'h0000_0001, 1'b1,
      '{spq_pkg::ST_FULL, 32'h0, 32'h0, 4'd8}},
    // drain in priority order
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'hdead_beef, 32'hcafe_f00d, 1'b1,
      '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 4'd0}},
    // alternating bit patterns, head back to slot zero after emptying
    '{spq_pkg::REQ_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
    '{spq_pkg::REQ_INSERT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{spq_pkg::REQ_REMOVE, 32'h0, 32'h0, 1'b1,
      '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 4'd0}}
  };

  logic         clk_i = 1'b0;
  logic         rst_n = 1'b0;
  logic         req_valid = 1'b0;
  logic         req_type = spq_pkg::REQ_INSERT;
  logic [63:0]  req_data = '0;
  logic         res_ready = 1'b0;
  logic         tag_typed = 1'b0;
  result_t      tag_want = '0;

  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [71:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  entry_t       held_entries[$];
  result_t      pending_results[$];
  int unsigned  mismatch_count = 0;

  always #1 clk_i = ~clk_i;

  sorted_priority_queue_top #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_data),      // [31:0] entry_value, [63:32] entry_priority
    .s_axis_tuser_i  (req_type),      // [0] req_type
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o), // [31:0] value, [63:32] priority, [67:64] occupancy
    .m_axis_tuser_o  (m_axis_tuser_o)  // [1:0] status
  );

  task automatic flag_mismatch(string msg);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sorted insert behind equal priorities; remove pops the head.
  function automatic result_t serve_request(logic req, logic [31:0] val,
                                            logic signed [31:0] pri);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (req == spq_pkg::REQ_INSERT) begin
      if (held_entries.size() >= QueueDepth) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio <= pri) pos++;
        e.value = val;
        e.prio = pri;
        held_entries.insert(pos, e);
      end
    end else if (held_entries.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      e = held_entries.pop_front();
      r.value = e.value;
      r.prio = e.prio;
    end
    r.occ = 4'(held_entries.size());
    return r;
  endfunction

  // Both channels sampled at the edge; values seen here are the pre-edge ones.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (m_axis_tvalid_o && res_ready) begin
        got.status = spq_pkg::status_e'(m_axis_tuser_o);
        got.value = m_axis_tdata_o[31:0];
        got.prio = m_axis_tdata_o[63:32];
        got.occ = m_axis_tdata_o[67:64];
        if (pending_results.size() == 0) begin
          flag_mismatch("result transfer with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.value != want.value)
            flag_mismatch($sformatf("value %h, want %h", got.value, want.value));
          if (got.prio != want.prio)
            flag_mismatch($sformatf("priority %h, want %h", got.prio, want.prio));
          if (got.occ != want.occ)
            flag_mismatch($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
        end
      end
      if (req_valid && s_axis_tready_o) begin
        want = serve_request(req_type, req_data[31:0], req_data[63:32]);
        pending_results.push_back(tag_typed ? tag_want : want);
      end
    end
  end

  // Holds one request on s_axis until its transfer; gap cycles idle first.
  task automatic offer(logic req, logic [31:0] val, logic [31:0] pri,
                       logic typed, result_t want, int unsigned gap);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_type  <= req;
    req_data  <= {pri, val};
    tag_typed <= typed;
    tag_want  <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Request source: reset, opening table, then mixed random traffic.
  initial begin
    logic         quiet;
    logic         req;
    logic [31:0]  pri;
    int unsigned  insert_pct;
    int unsigned  gap;
    quiet = 1'b0;
    insert_pct = 50;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < OpeningN; i++) begin
      gap = $urandom_range(0, 8);
      offer(OpeningSteps[i].req, OpeningSteps[i].value, OpeningSteps[i].prio,
            OpeningSteps[i].typed, OpeningSteps[i].want, gap);
    end

    for (int n = 0; n < RandomN; n++) begin
      // fill, drain and balanced phases so the queue swings between full and empty
      if (n % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == 330) wait_drained();
      req = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::REQ_INSERT
                                                 : spq_pkg::REQ_REMOVE;
      // mostly narrow keys so ties are common
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pri = $urandom_range(0, 7);
        5, 6: pri = 32'($urandom_range(0, 7)) - 32'd4;
        7, 8: pri = $urandom;
        default: begin
          case ($urandom_range(0, 3))
            0: pri = 32'h8000_0000;
            1: pri = 32'h7fff_ffff;
            2: pri = 32'h0000_0000;
            default: pri = 32'hffff_ffff;
          endcase
        end
      endcase
      gap = quiet ? 0 : $urandom_range(0, 8);
      offer(req, $urandom, pri, 1'b0, '0, gap);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result sink: random backpressure, calm stretches, and one long hold so the
  // block fills its output register and stalls s_axis.
  initial begin
    logic         calm;
    int unsigned  taken;
    int unsigned  wait_n;
    calm = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      wait_n = calm ? 0 : $urandom_range(0, 8);
      if (taken == 150) wait_n = LongHold;
      if (wait_n != 0) begin
        res_ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sorted_priority_queue_top.f
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_dp.sv
rtl/core/sorted_priority_queue_top.sv
verif/sorted_priority_queue_top_test.sv
